@@ src/keyframe_vec3_track_sampler_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyframe sampler
// Shared concurrent assertion forms, clocked on clk with async low reset.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VEC3_TRACK_SAMPLER_UNIT_MACROS_SVH
`define KEYFRAME_VEC3_TRACK_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define KVTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KVTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/kvts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvts_pkg
// Shared constants and types of the keyframe track sampler.
// ----------------------------------------------------------------------------
package kvts_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int KEY_AW    = $clog2(MAX_KEYS);
    localparam int KCOUNT_W  = KEY_AW + 1;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 3 * DATA_W;
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 104;
    localparam int PADDR_W   = 3;

    // divider: 32-bit magnitude shifted by 16 fraction bits
    localparam int DIV_STEPS = 48;
    localparam int DIV_CW    = 6;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic REG_KEY_COUNT = 1'b0;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DT = 2'd1;
    localparam logic [1:0] STATUS_SAT     = 2'd2;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                     done;
        logic                     sat;
        logic signed [DATA_W-1:0] factor;
    } div_res_t;

endpackage

@@ src/kvts_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvts_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kvts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/kvts_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvts_div
// Iterative signed divider for the interpolation factor (num << 16) / den,
// one quotient bit per cycle, truncated toward zero and clamped to 32 bits.
// ----------------------------------------------------------------------------
module kvts_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [32:0]     num,
    input  logic signed [32:0]     den,
    output kvts_pkg::div_res_t     res
);

    logic                                run_reg;
    logic                                done_reg;
    logic [kvts_pkg::DIV_CW-1:0]         cnt_reg;
    logic                                neg_reg;
    logic [kvts_pkg::DATA_W-1:0]         dsr_reg;
    logic [kvts_pkg::DATA_W-1:0]         rem_reg;
    logic [kvts_pkg::DIV_STEPS-1:0]      dvd_reg;

    logic [32:0]                         num_mag_c;
    logic [32:0]                         den_mag_c;
    logic [32:0]                         rem_sh_c;
    logic                                ge_c;
    logic                                sat_c;
    logic [kvts_pkg::DATA_W-1:0]         fac_c;

    assign num_mag_c = num[32] ? 33'(-num) : 33'(num);
    assign den_mag_c = den[32] ? 33'(-den) : 33'(den);

    assign rem_sh_c = {rem_reg, dvd_reg[kvts_pkg::DIV_STEPS-1]};
    assign ge_c     = (rem_sh_c >= {1'b0, dsr_reg});

    // quotient sits in dvd_reg once all bits are shifted through
    always_comb
    begin
        if (neg_reg)
        begin
            sat_c = (|dvd_reg[47:32]) || (dvd_reg[31] && (|dvd_reg[30:0]));
            fac_c = sat_c ? kvts_pkg::Q_MIN : 32'(~dvd_reg[31:0] + 32'd1);
        end
        else
        begin
            sat_c = |dvd_reg[47:31];
            fac_c = sat_c ? kvts_pkg::Q_MAX : dvd_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == kvts_pkg::DIV_CW'(kvts_pkg::DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[32] ^ den[32];
            dsr_reg <= den_mag_c[31:0];
            rem_reg <= '0;
            dvd_reg <= {num_mag_c[31:0], 16'd0};
        end
        else if (run_reg)
        begin
            rem_reg <= ge_c ? 32'(rem_sh_c - {1'b0, dsr_reg}) : rem_sh_c[31:0];
            dvd_reg <= {dvd_reg[kvts_pkg::DIV_STEPS-2:0], ge_c};
        end
    end

    assign res.done   = done_reg;
    assign res.sat    = sat_c;
    assign res.factor = fac_c;

endmodule

@@ src/keyframe_vec3_track_sampler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_vec3_track_sampler_unit
// Keyframe track store with linear interpolation of (x, y, z) in Q16.16.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Content
//  s_*       in         tvalid/tready      key load or sample request
//  m_*       out        tvalid/tready      interpolated vector, segment, status
//  apb       in         psel/penable       key_count register at 0x0
//
//  Load: written straight into the key RAMs.
//  Sample for n keys in use: a linear search reading one key time a cycle,
//  a bit-serial divider, then one shared multiplier used once per component.
//  One key in use: the search, the divider and the multiplier are skipped.
//  The key RAMs have no reset; key_count resets to 1.
//  A stalled result holds in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module keyframe_vec3_track_sampler_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // key_index[5:0], key_time[37:6], key_x[69:38], key_y[101:70],
    // key_z[133:102], sample_time[165:134], zero pad
    input  logic [kvts_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type[0]
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], segment_index[101:96], zero pad
    output logic [kvts_pkg::M_TDATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [1:0]                           m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kvts_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    `include "keyframe_vec3_track_sampler_unit_macros.svh"

    typedef enum logic [3:0] {
        IDLE,
        SEARCH,
        FETCH_A,
        FETCH_B,
        FETCH_C,
        CHECK,
        DIV,
        MUL,
        ACC,
        OUT
    } state_t;

    // input fields
    logic [kvts_pkg::KEY_AW-1:0]          key_index;
    logic [kvts_pkg::DATA_W-1:0]          key_time;
    logic [kvts_pkg::DATA_W-1:0]          key_x;
    logic [kvts_pkg::DATA_W-1:0]          key_y;
    logic [kvts_pkg::DATA_W-1:0]          key_z;
    logic [kvts_pkg::DATA_W-1:0]          sample_time;

    // control
    state_t                               state_reg;
    logic                                 m_tvalid_reg;
    logic [kvts_pkg::KCOUNT_W-1:0]        key_count_reg;
    logic [kvts_pkg::KCOUNT_W-1:0]        nkeys_reg;
    logic                                 single_reg;
    logic                                 cmp_valid_reg;
    logic [kvts_pkg::KEY_AW-1:0]          rd_idx_reg;
    logic [kvts_pkg::KEY_AW-1:0]          cmp_seg_reg;
    logic [kvts_pkg::KEY_AW-1:0]          seg_reg;
    logic [1:0]                           comp_reg;
    logic                                 sat_reg;

    // payload
    logic [kvts_pkg::DATA_W-1:0]          t_reg;
    logic [kvts_pkg::DATA_W-1:0]          t0_reg;
    logic [kvts_pkg::DATA_W-1:0]          t1_reg;
    logic [2:0][kvts_pkg::DATA_W-1:0]     p0_reg;
    logic [2:0][kvts_pkg::DATA_W-1:0]     p1_reg;
    logic signed [kvts_pkg::DATA_W-1:0]   factor_reg;
    logic signed [64:0]                   prod_reg;
    logic [2:0][kvts_pkg::DATA_W-1:0]     res_reg;
    logic [1:0]                           status_reg;
    logic [2:0][kvts_pkg::DATA_W-1:0]     out_res_reg;
    logic [kvts_pkg::KEY_AW-1:0]          out_seg_reg;
    logic [1:0]                           out_status_reg;

    logic                                 s_acc_c;
    logic                                 cfg_wr_c;
    logic                                 out_load_c;
    logic [kvts_pkg::KCOUNT_W-1:0]        n_c;
    logic                                 last_cmp_c;
    logic                                 ram_we_c;
    logic [kvts_pkg::KEY_AW-1:0]          raddr_c;
    logic [kvts_pkg::DATA_W-1:0]          time_rdata;
    logic [kvts_pkg::POS_W-1:0]           pos_rdata;
    logic                                 div_start_c;
    logic signed [32:0]                   num_c;
    logic signed [32:0]                   dt_c;
    kvts_pkg::div_res_t                   div_res;
    logic signed [kvts_pkg::DATA_W-1:0]   p0_c;
    logic signed [kvts_pkg::DATA_W-1:0]   p1_c;
    logic signed [32:0]                   d_c;
    logic                                 rnd_c;
    logic signed [48:0]                   off_c;
    logic signed [49:0]                   sum_c;
    logic                                 comp_sat_c;
    logic [kvts_pkg::DATA_W-1:0]          comp_res_c;

    assign key_index   = s_tdata[5:0];
    assign key_time    = s_tdata[37:6];
    assign key_x       = s_tdata[69:38];
    assign key_y       = s_tdata[101:70];
    assign key_z       = s_tdata[133:102];
    assign sample_time = s_tdata[165:134];

    assign s_tready   = (state_reg == IDLE);
    assign s_acc_c    = s_tvalid && s_tready;
    assign out_load_c = (state_reg == OUT) && (!m_tvalid_reg || m_tready);

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign cfg_wr_c = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == kvts_pkg::REG_KEY_COUNT) ?
                      32'(key_count_reg) : 32'd0;

    // zero acts as one key, anything beyond the store as a full store
    always_comb
    begin
        if (key_count_reg == '0)
        begin
            n_c = kvts_pkg::KCOUNT_W'(1);
        end
        else if (key_count_reg > kvts_pkg::KCOUNT_W'(kvts_pkg::MAX_KEYS))
        begin
            n_c = kvts_pkg::KCOUNT_W'(kvts_pkg::MAX_KEYS);
        end
        else
        begin
            n_c = key_count_reg;
        end
    end

    // ---------------- key memories ----------------
    // Writes only happen on an accepted load in IDLE, and read data is only used
    // while a sample is in flight, so no write collides with a read in use.
    assign ram_we_c = s_acc_c && (s_tuser == kvts_pkg::REQ_LOAD);

    always_comb
    begin
        case (state_reg)
            FETCH_A: raddr_c = seg_reg;
            FETCH_B: raddr_c = seg_reg + 1'b1;
            default: raddr_c = rd_idx_reg;
        endcase
    end

    kvts_ram #(
        .WIDTH (kvts_pkg::DATA_W),
        .DEPTH (kvts_pkg::MAX_KEYS)
    ) u_time_ram (
        .clk   (clk),
        .we    (ram_we_c),
        .waddr (key_index),
        .wdata (key_time),
        .raddr (raddr_c),
        .rdata (time_rdata)
    );

    kvts_ram #(
        .WIDTH (kvts_pkg::POS_W),
        .DEPTH (kvts_pkg::MAX_KEYS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (ram_we_c),
        .waddr (key_index),
        .wdata ({key_z, key_y, key_x}),
        .raddr (raddr_c),
        .rdata (pos_rdata)
    );

    // ---------------- divider ----------------
    assign num_c       = $signed({1'b0, t_reg}) - $signed({1'b0, t0_reg});
    assign dt_c        = $signed({1'b0, t1_reg}) - $signed({1'b0, t0_reg});
    assign div_start_c = (state_reg == CHECK) && (t1_reg != t0_reg);

    kvts_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_c),
        .num   (num_c),
        .den   (dt_c),
        .res   (div_res)
    );

    // ---------------- per-component lerp ----------------
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                p0_c = p0_reg[0];
                p1_c = p1_reg[0];
            end
            2'd1:
            begin
                p0_c = p0_reg[1];
                p1_c = p1_reg[1];
            end
            2'd2:
            begin
                p0_c = p0_reg[2];
                p1_c = p1_reg[2];
            end
            default:
            begin
                p0_c = '0;
                p1_c = '0;
            end
        endcase
    end

    assign d_c = 33'(p1_c) - 33'(p0_c);

    // product / 65536 truncated toward zero
    assign rnd_c = prod_reg[64] && (|prod_reg[15:0]);
    assign off_c = $signed(prod_reg[64:16]) + $signed({48'd0, rnd_c});
    assign sum_c = 50'(p0_c) + 50'(off_c);

    always_comb
    begin
        comp_sat_c = 1'b0;
        comp_res_c = sum_c[31:0];
        if (!sum_c[49] && (|sum_c[48:31]))
        begin
            comp_sat_c = 1'b1;
            comp_res_c = kvts_pkg::Q_MAX;
        end
        else if (sum_c[49] && !(&sum_c[48:31]))
        begin
            comp_sat_c = 1'b1;
            comp_res_c = kvts_pkg::Q_MIN;
        end
    end

    // ---------------- sequencer ----------------
    assign last_cmp_c = ((kvts_pkg::KCOUNT_W'(cmp_seg_reg) + kvts_pkg::KCOUNT_W'(2))
                         == nkeys_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            m_tvalid_reg   <= 1'b0;
            key_count_reg  <= kvts_pkg::KCOUNT_W'(1);
            nkeys_reg      <= kvts_pkg::KCOUNT_W'(1);
            single_reg     <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            rd_idx_reg     <= '0;
            cmp_seg_reg    <= '0;
            seg_reg        <= '0;
            comp_reg       <= '0;
            sat_reg        <= 1'b0;
            out_res_reg    <= '0;
            out_seg_reg    <= '0;
            out_status_reg <= kvts_pkg::STATUS_OK;
        end
        else
        begin
            if (cfg_wr_c && (paddr[2] == kvts_pkg::REG_KEY_COUNT))
            begin
                key_count_reg <= pwdata[kvts_pkg::KCOUNT_W-1:0];
            end

            // a new result may replace one taken in the same cycle
            if (out_load_c)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                IDLE:
                begin
                    if (s_acc_c && (s_tuser == kvts_pkg::REQ_SAMPLE))
                    begin
                        nkeys_reg     <= n_c;
                        rd_idx_reg    <= kvts_pkg::KEY_AW'(1);
                        cmp_valid_reg <= 1'b0;
                        cmp_seg_reg   <= '0;
                        seg_reg       <= '0;
                        sat_reg       <= 1'b0;
                        single_reg    <= (n_c == kvts_pkg::KCOUNT_W'(1));
                        state_reg     <= (n_c == kvts_pkg::KCOUNT_W'(1)) ? FETCH_A : SEARCH;
                    end
                end
                SEARCH:
                begin
                    // one key time issued per cycle, compared in the next cycle
                    rd_idx_reg    <= rd_idx_reg + 1'b1;
                    cmp_valid_reg <= 1'b1;
                    if (cmp_valid_reg)
                    begin
                        cmp_seg_reg <= cmp_seg_reg + 1'b1;
                        if (t_reg < time_rdata)
                        begin
                            seg_reg   <= cmp_seg_reg;
                            state_reg <= FETCH_A;
                        end
                        else if (last_cmp_c)
                        begin
                            seg_reg   <= '0;
                            state_reg <= FETCH_A;
                        end
                    end
                end
                FETCH_A:
                begin
                    state_reg <= FETCH_B;
                end
                FETCH_B:
                begin
                    state_reg <= single_reg ? OUT : FETCH_C;
                end
                FETCH_C:
                begin
                    state_reg <= CHECK;
                end
                CHECK:
                begin
                    state_reg <= (t1_reg == t0_reg) ? OUT : DIV;
                end
                DIV:
                begin
                    if (div_res.done)
                    begin
                        sat_reg   <= div_res.sat;
                        comp_reg  <= '0;
                        state_reg <= MUL;
                    end
                end
                MUL:
                begin
                    state_reg <= ACC;
                end
                ACC:
                begin
                    sat_reg <= sat_reg || comp_sat_c;
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= OUT;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= MUL;
                    end
                end
                OUT:
                begin
                    if (out_load_c)
                    begin
                        out_res_reg    <= res_reg;
                        out_seg_reg    <= seg_reg;
                        out_status_reg <= status_reg;
                        state_reg      <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            IDLE:
            begin
                if (s_acc_c)
                begin
                    t_reg <= sample_time;
                end
            end
            FETCH_B:
            begin
                t0_reg <= time_rdata;
                p0_reg <= pos_rdata;
                if (single_reg)
                begin
                    res_reg    <= pos_rdata;
                    status_reg <= kvts_pkg::STATUS_OK;
                end
            end
            FETCH_C:
            begin
                t1_reg <= time_rdata;
                p1_reg <= pos_rdata;
            end
            CHECK:
            begin
                if (t1_reg == t0_reg)
                begin
                    res_reg    <= p0_reg;
                    status_reg <= kvts_pkg::STATUS_ZERO_DT;
                end
            end
            DIV:
            begin
                if (div_res.done)
                begin
                    factor_reg <= div_res.factor;
                end
            end
            MUL:
            begin
                prod_reg <= 65'(d_c) * 65'(factor_reg);
            end
            ACC:
            begin
                res_reg[comp_reg] <= comp_res_c;
                if (comp_reg == 2'd2)
                begin
                    status_reg <= (sat_reg || comp_sat_c) ?
                                  kvts_pkg::STATUS_SAT : kvts_pkg::STATUS_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_seg_reg, out_res_reg[2], out_res_reg[1], out_res_reg[0]};
    assign m_tuser  = out_status_reg;

    // ---------------- assertions ----------------
    `KVTS_ASSERT_IMP(a_no_write_busy, clk, rst_n, state_reg != IDLE, !ram_we_c,
        "key RAM written while a sample is in flight")

    `KVTS_ASSERT_IMP(a_div_done_state, clk, rst_n, div_res.done, state_reg == DIV,
        "divider finished outside the divide phase")

    `KVTS_ASSERT_NXT(a_out_holds, clk, rst_n,
        (state_reg == OUT) && m_tvalid_reg && !m_tready, state_reg == OUT,
        "finished result dropped while output register was full")

    `KVTS_ASSERT_IMP(a_search_bound, clk, rst_n,
        (state_reg == SEARCH) && cmp_valid_reg,
        (kvts_pkg::KCOUNT_W'(cmp_seg_reg) + kvts_pkg::KCOUNT_W'(2)) <= nkeys_reg,
        "search ran past the last segment in use")

    `KVTS_ASSERT_IMP(a_seg_in_range, clk, rst_n, state_reg == FETCH_C,
        (kvts_pkg::KCOUNT_W'(seg_reg) + kvts_pkg::KCOUNT_W'(1)) < nkeys_reg,
        "segment end key outside the keys in use")

endmodule
